// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/fle_pkg.sv =====
package fle_pkg;

  localparam int FRAC_BITS    = 24;
  localparam int ANG_BITS     = 30;
  localparam int CORDIC_ITERS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int QW           = ANG_BITS + 1;
  localparam int CW           = 32 + (ANG_BITS - FRAC_BITS) + 4;
  localparam int ZW           = ANG_BITS + 4;

  localparam logic [QW-1:0] HALF_PI   = QW'(1686629713);
  localparam logic [QW-1:0] ONE_Q     = QW'(64'd1 << ANG_BITS);
  localparam logic [31:0]   NEAR_AXIS = 32'((64'd1 << FRAC_BITS) / 64'd1000000);

  localparam logic [2:0] CFG_K1 = 3'd0;
  localparam logic [2:0] CFG_K2 = 3'd1;
  localparam logic [2:0] CFG_K3 = 3'd2;
  localparam logic [2:0] CFG_K4 = 3'd3;

  typedef struct packed {
    logic               near;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } side_t;

  function automatic logic [ANG_BITS-1:0] atan_tab(input int idx);
    logic [ANG_BITS-1:0] val;
    case (idx)
      0: val = 30'd843314857;
      1: val = 30'd497837829;
      2: val = 30'd263043837;
      3: val = 30'd133525159;
      4: val = 30'd67021687;
      5: val = 30'd33543516;
      6: val = 30'd16775851;
      7: val = 30'd8388437;
      8: val = 30'd4194283;
      9: val = 30'd2097149;
      default: val = ANG_BITS'(64'd1 << (ANG_BITS - idx));
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/fle_sqrt.sv =====
module fle_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  in_u,
  input  logic signed [31:0]  in_v,
  output logic                out_valid,
  output logic [31:0]         out_root,
  output fle_pkg::side_t      out_side
);
  localparam int Steps = fle_pkg::SQRT_STEPS;

  logic               pre_valid_r;
  logic [63:0]        uu_r;
  logic [63:0]        vv_r;
  fle_pkg::side_t     pre_side_r;
  logic signed [63:0] u_wide;
  logic signed [63:0] v_wide;
  logic               vld_r  [Steps];
  logic [63:0]        rem_r  [Steps];
  logic [31:0]        root_r [Steps];
  fle_pkg::side_t     side_r [Steps];

  assign u_wide = 64'(in_u);
  assign v_wide = 64'(in_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (en) begin
      pre_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r       <= 64'(u_wide * u_wide);
      vv_r       <= 64'(v_wide * v_wide);
      pre_side_r <= '{near: 1'b0, u: in_u, v: in_v};
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int B = Steps - 1 - k;
    logic           v_in;
    logic [63:0]    rem_in;
    logic [31:0]    root_in;
    fle_pkg::side_t side_in;
    logic [63:0]    trial;

    if (k == 0) begin : g_head
      assign v_in    = pre_valid_r;
      assign rem_in  = uu_r + vv_r;
      assign root_in = '0;
      assign side_in = pre_side_r;
    end else begin : g_tail
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = ({32'd0, root_in} << (B + 1)) + (64'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        if (rem_in >= trial) begin
          rem_r[k]  <= rem_in - trial;
          root_r[k] <= root_in | (32'd1 << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign out_valid = vld_r[Steps-1];
  assign out_root  = root_r[Steps-1];
  assign out_side  = side_r[Steps-1];

endmodule

// ===== rtl/core/fle_cordic.sv =====
module fle_cordic (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [31:0]                 in_r,
  input  fle_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [fle_pkg::QW-1:0]      out_theta,
  output logic [31:0]                 out_r,
  output fle_pkg::side_t              out_side
);
  localparam int Iters = fle_pkg::CORDIC_ITERS;
  localparam int Cw    = fle_pkg::CW;
  localparam int Zw    = fle_pkg::ZW;
  localparam int Qw    = fle_pkg::QW;
  localparam int Sh    = fle_pkg::ANG_BITS - fle_pkg::FRAC_BITS;

  logic                  v0_r;
  logic signed [Cw-1:0]  x0_r;
  logic signed [Cw-1:0]  y0_r;
  logic [31:0]           r0_r;
  fle_pkg::side_t        side0_r;
  fle_pkg::side_t        side0_nxt;

  logic                  vld_r  [Iters];
  logic signed [Cw-1:0]  x_r    [Iters];
  logic signed [Cw-1:0]  y_r    [Iters];
  logic signed [Zw-1:0]  z_r    [Iters];
  logic [31:0]           r_r    [Iters];
  fle_pkg::side_t        side_r [Iters];

  logic                  out_valid_r;
  logic [Qw-1:0]         out_theta_r;
  logic [Qw-1:0]         theta_nxt;
  logic [31:0]           out_r_r;
  fle_pkg::side_t        out_side_r;
  logic signed [Zw-1:0]  z_last;

  always_comb begin
    side0_nxt      = in_side;
    side0_nxt.near = (in_r <= fle_pkg::NEAR_AXIS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= Cw'(64'd1 << fle_pkg::ANG_BITS);
      y0_r    <= Cw'({{(Cw - 32){1'b0}}, in_r} << Sh);
      r0_r    <= in_r;
      side0_r <= side0_nxt;
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_iter
    logic                 v_in;
    logic signed [Cw-1:0] x_in;
    logic signed [Cw-1:0] y_in;
    logic signed [Zw-1:0] z_in;
    logic [31:0]          r_in;
    fle_pkg::side_t       side_in;
    logic signed [Cw-1:0] xs;
    logic signed [Cw-1:0] ys;
    logic [Zw-1:0]        ang;

    if (i == 0) begin : g_head
      assign v_in    = v0_r;
      assign x_in    = x0_r;
      assign y_in    = y0_r;
      assign z_in    = '0;
      assign r_in    = r0_r;
      assign side_in = side0_r;
    end else begin : g_tail
      assign v_in    = vld_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign r_in    = r_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign xs  = x_in >>> i;
    assign ys  = y_in >>> i;
    assign ang = {{(Zw - fle_pkg::ANG_BITS){1'b0}}, fle_pkg::atan_tab(i)};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]    <= r_in;
        side_r[i] <= side_in;
        if (!y_in[Cw-1] && (y_in != '0)) begin
          x_r[i] <= x_in + ys;
          y_r[i] <= y_in - xs;
          z_r[i] <= z_in + $signed(ang);
        end else begin
          x_r[i] <= x_in - ys;
          y_r[i] <= y_in + xs;
          z_r[i] <= z_in - $signed(ang);
        end
      end
    end
  end

  assign z_last = z_r[Iters-1];

  always_comb begin
    if (z_last[Zw-1]) begin
      theta_nxt = '0;
    end else if (z_last > $signed({{(Zw - Qw){1'b0}}, fle_pkg::HALF_PI})) begin
      theta_nxt = fle_pkg::HALF_PI;
    end else begin
      theta_nxt = z_last[Qw-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[Iters-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_theta_r <= theta_nxt;
      out_r_r     <= r_r[Iters-1];
      out_side_r  <= side_r[Iters-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_theta = out_theta_r;
  assign out_r     = out_r_r;
  assign out_side  = out_side_r;

endmodule

// ===== rtl/core/fle_div.sv =====
module fle_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [fle_pkg::QW-1:0]  in_theta,
  input  logic [31:0]             in_r,
  input  fle_pkg::side_t          in_side,
  output logic                    out_valid,
  output logic [fle_pkg::QW-1:0]  out_q,
  output logic [fle_pkg::QW-1:0]  out_theta,
  output fle_pkg::side_t          out_side
);
  localparam int Qw = fle_pkg::QW;

  logic           v0_r;
  logic [63:0]    rem0_r;
  logic           ovf0_r;
  logic [31:0]    r0_r;
  logic [Qw-1:0]  th0_r;
  fle_pkg::side_t side0_r;
  logic [63:0]    dvd;

  logic           vld_r  [Qw];
  logic [63:0]    rem_r  [Qw];
  logic [Qw-1:0]  q_r    [Qw];
  logic           ovf_r  [Qw];
  logic [31:0]    r_r    [Qw];
  logic [Qw-1:0]  th_r   [Qw];
  fle_pkg::side_t side_r [Qw];

  logic           out_valid_r;
  logic [Qw-1:0]  out_q_r;
  logic [Qw-1:0]  out_theta_r;
  fle_pkg::side_t out_side_r;

  assign dvd = {{(64 - Qw){1'b0}}, in_theta} << fle_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r  <= dvd;
      ovf0_r  <= (dvd >= ({32'd0, in_r} << Qw));
      r0_r    <= in_r;
      th0_r   <= in_theta;
      side0_r <= in_side;
    end
  end

  for (genvar j = 0; j < Qw; j++) begin : g_bit
    localparam int B = Qw - 1 - j;
    logic           v_in;
    logic [63:0]    rem_in;
    logic [Qw-1:0]  q_in;
    logic           ovf_in;
    logic [31:0]    r_in;
    logic [Qw-1:0]  th_in;
    fle_pkg::side_t side_in;
    logic [63:0]    trial;

    if (j == 0) begin : g_head
      assign v_in    = v0_r;
      assign rem_in  = rem0_r;
      assign q_in    = '0;
      assign ovf_in  = ovf0_r;
      assign r_in    = r0_r;
      assign th_in   = th0_r;
      assign side_in = side0_r;
    end else begin : g_tail
      assign v_in    = vld_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign ovf_in  = ovf_r[j-1];
      assign r_in    = r_r[j-1];
      assign th_in   = th_r[j-1];
      assign side_in = side_r[j-1];
    end

    assign trial = {32'd0, r_in} << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[j]  <= ovf_in;
        r_r[j]    <= r_in;
        th_r[j]   <= th_in;
        side_r[j] <= side_in;
        if (rem_in >= trial) begin
          rem_r[j] <= rem_in - trial;
          q_r[j]   <= q_in | (Qw'(1) << B);
        end else begin
          rem_r[j] <= rem_in;
          q_r[j]   <= q_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[Qw-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_r[Qw-1] || (q_r[Qw-1] > fle_pkg::ONE_Q)) begin
        out_q_r <= fle_pkg::ONE_Q;
      end else begin
        out_q_r <= q_r[Qw-1];
      end
      out_theta_r <= th_r[Qw-1];
      out_side_r  <= side_r[Qw-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_q     = out_q_r;
  assign out_theta = out_theta_r;
  assign out_side  = out_side_r;

endmodule

// ===== rtl/core/fle_poly.sv =====
module fle_poly (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [fle_pkg::QW-1:0]  in_theta,
  input  logic [fle_pkg::QW-1:0]  in_q,
  input  fle_pkg::side_t          in_side,
  input  logic signed [31:0]      coef_k1,
  input  logic signed [31:0]      coef_k2,
  input  logic signed [31:0]      coef_k3,
  input  logic signed [31:0]      coef_k4,
  output logic                    out_valid,
  output logic signed [31:0]      out_offset_x,
  output logic signed [31:0]      out_offset_y,
  output logic                    out_saturated
);
  localparam int Qw     = fle_pkg::QW;
  localparam int Stages = 15;
  localparam int Mw     = 45;
  localparam logic signed [63:0] P_ONE   = 64'sd1 <<< 52;
  localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

  logic           vld_r  [Stages];
  fle_pkg::side_t side_r [Stages];
  logic [Qw-1:0]  q_r    [Stages];

  logic [2*Qw-1:0]     th2_r;
  logic [29:0]         t2_r;
  logic [59:0]         t4p_r;
  logic [29:0]         t2b_r;
  logic [30:0]         t4_r;
  logic [29:0]         t2c_r;
  logic [60:0]         t6p_r;
  logic [61:0]         t8p_r;
  logic [29:0]         t2d_r;
  logic [30:0]         t4d_r;
  logic [29:0]         t2s_r;
  logic [29:0]         t4s_r;
  logic [29:0]         t6s_r;
  logic [29:0]         t8s_r;
  logic signed [62:0]  pk1_r;
  logic signed [62:0]  pk2_r;
  logic signed [62:0]  pk3_r;
  logic signed [62:0]  pk4_r;
  logic signed [63:0]  p_r;
  logic                pneg_r;
  logic [41:0]         pmag_r;
  logic [51:0]         pa_lo_r;
  logic [51:0]         pa_hi_r;
  logic                pneg2_r;
  logic [72:0]         pfull_r;
  logic                pneg3_r;
  logic signed [Mw-1:0] m_r;
  logic                mneg_r;
  logic [Mw-1:0]       mmag_r;
  logic                uneg_r;
  logic                vneg_r;
  logic [31:0]         umag_r;
  logic [31:0]         vmag_r;
  logic [54:0]         xa_lo_r;
  logic [53:0]         xa_hi_r;
  logic [54:0]         ya_lo_r;
  logic [53:0]         ya_hi_r;
  logic                xneg_r;
  logic                yneg_r;
  logic [76:0]         xfull_r;
  logic [76:0]         yfull_r;
  logic                xneg2_r;
  logic                yneg2_r;

  logic                out_valid_r;
  logic signed [31:0]  out_offset_x_r;
  logic signed [31:0]  out_offset_y_r;
  logic                out_saturated_r;

  logic [62:0]         th2_sum;
  logic [60:0]         t4_sum;
  logic [61:0]         t6_sum;
  logic [62:0]         t8_sum;
  logic [32:0]         t6_nxt;
  logic [34:0]         t8_nxt;
  logic [30:0]         t2s_sum;
  logic [31:0]         t4s_sum;
  logic [33:0]         t6s_sum;
  logic [35:0]         t8s_sum;
  logic signed [63:0]  p_round;
  logic signed [41:0]  p30_nxt;
  logic [72:0]         r_sum;
  logic [42:0]         rmag;
  logic signed [Mw-1:0] ratio_nxt;
  logic [76:0]         xr_sum;
  logic [76:0]         yr_sum;
  logic signed [47:0]  xv_nxt;
  logic signed [47:0]  yv_nxt;
  logic [31:0]         ox_nxt;
  logic [31:0]         oy_nxt;
  logic                sat_nxt;
  fle_pkg::side_t      last_side;

  for (genvar s = 0; s < Stages; s++) begin : g_ctl
    logic           v_in;
    fle_pkg::side_t side_in;
    logic [Qw-1:0]  q_in;
    if (s == 0) begin : g_head
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign q_in    = in_q;
    end else begin : g_tail
      assign v_in    = vld_r[s-1];
      assign side_in = side_r[s-1];
      assign q_in    = q_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_in;
        q_r[s]    <= q_in;
      end
    end
  end

  assign th2_sum   = {1'b0, th2_r} + (63'd1 << 31);
  assign t4_sum    = {1'b0, t4p_r} + (61'd1 << 27);
  assign t6_sum    = {1'b0, t6p_r} + (62'd1 << 27);
  assign t8_sum    = {1'b0, t8p_r} + (63'd1 << 27);
  assign t6_nxt    = t6_sum[60:28];
  assign t8_nxt    = t8_sum[62:28];
  assign t2s_sum   = {1'b0, t2d_r} + 31'd8;
  assign t4s_sum   = {1'b0, t4d_r} + 32'd8;
  assign t6s_sum   = {1'b0, t6_nxt} + 34'd8;
  assign t8s_sum   = {1'b0, t8_nxt} + 36'd8;
  assign p_round   = p_r + (64'sd1 <<< 21);
  assign p30_nxt   = 42'(p_round >>> 22);
  assign r_sum     = pfull_r + (73'd1 << 29);
  assign rmag      = r_sum[72:30];
  assign ratio_nxt = pneg3_r ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
  assign xr_sum    = xfull_r + (77'd1 << 29);
  assign yr_sum    = yfull_r + (77'd1 << 29);
  assign xv_nxt    = xneg2_r ? -$signed({1'b0, xr_sum[76:30]}) : $signed({1'b0, xr_sum[76:30]});
  assign yv_nxt    = yneg2_r ? -$signed({1'b0, yr_sum[76:30]}) : $signed({1'b0, yr_sum[76:30]});
  assign last_side = side_r[Stages-1];

  always_comb begin
    sat_nxt = 1'b0;
    if (xv_nxt > SAT_MAX) begin
      ox_nxt  = 32'h7fff_ffff;
      sat_nxt = 1'b1;
    end else if (xv_nxt < SAT_MIN) begin
      ox_nxt  = 32'h8000_0000;
      sat_nxt = 1'b1;
    end else begin
      ox_nxt = xv_nxt[31:0];
    end
    if (yv_nxt > SAT_MAX) begin
      oy_nxt  = 32'h7fff_ffff;
      sat_nxt = 1'b1;
    end else if (yv_nxt < SAT_MIN) begin
      oy_nxt  = 32'h8000_0000;
      sat_nxt = 1'b1;
    end else begin
      oy_nxt = yv_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th2_r   <= in_theta * in_theta;
      t2_r    <= th2_sum[61:32];
      t4p_r   <= t2_r * t2_r;
      t2b_r   <= t2_r;
      t4_r    <= t4_sum[58:28];
      t2c_r   <= t2b_r;
      t6p_r   <= t4_r * t2c_r;
      t8p_r   <= t4_r * t4_r;
      t2d_r   <= t2c_r;
      t4d_r   <= t4_r;
      t2s_r   <= 30'(t2s_sum[30:4]);
      t4s_r   <= 30'(t4s_sum[31:4]);
      t6s_r   <= 30'(t6s_sum[33:4]);
      t8s_r   <= 30'(t8s_sum[35:4]);
      pk1_r   <= coef_k1 * $signed({1'b0, t2s_r});
      pk2_r   <= coef_k2 * $signed({1'b0, t4s_r});
      pk3_r   <= coef_k3 * $signed({1'b0, t6s_r});
      pk4_r   <= coef_k4 * $signed({1'b0, t8s_r});
      p_r     <= P_ONE + 64'(pk1_r) + 64'(pk2_r) + 64'(pk3_r) + 64'(pk4_r);
      pneg_r  <= p30_nxt[41];
      pmag_r  <= p30_nxt[41] ? 42'(-p30_nxt) : 42'(p30_nxt);
      pa_lo_r <= pmag_r[20:0] * q_r[8];
      pa_hi_r <= pmag_r[41:21] * q_r[8];
      pneg2_r <= pneg_r;
      pfull_r <= ({21'd0, pa_hi_r} << 21) + {21'd0, pa_lo_r};
      pneg3_r <= pneg2_r;
      m_r     <= ratio_nxt - ($signed(Mw'(1)) <<< fle_pkg::ANG_BITS);
      mneg_r  <= m_r[Mw-1];
      mmag_r  <= m_r[Mw-1] ? Mw'(-m_r) : Mw'(m_r);
      uneg_r  <= side_r[11].u[31];
      vneg_r  <= side_r[11].v[31];
      umag_r  <= side_r[11].u[31] ? 32'(-side_r[11].u) : 32'(side_r[11].u);
      vmag_r  <= side_r[11].v[31] ? 32'(-side_r[11].v) : 32'(side_r[11].v);
      xa_lo_r <= mmag_r[22:0] * umag_r;
      xa_hi_r <= mmag_r[Mw-1:23] * umag_r;
      ya_lo_r <= mmag_r[22:0] * vmag_r;
      ya_hi_r <= mmag_r[Mw-1:23] * vmag_r;
      xneg_r  <= mneg_r ^ uneg_r;
      yneg_r  <= mneg_r ^ vneg_r;
      xfull_r <= ({23'd0, xa_hi_r} << 23) + {22'd0, xa_lo_r};
      yfull_r <= ({23'd0, ya_hi_r} << 23) + {22'd0, ya_lo_r};
      xneg2_r <= xneg_r;
      yneg2_r <= yneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[Stages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (last_side.near) begin
        out_offset_x_r  <= '0;
        out_offset_y_r  <= '0;
        out_saturated_r <= 1'b0;
      end else begin
        out_offset_x_r  <= ox_nxt;
        out_offset_y_r  <= oy_nxt;
        out_saturated_r <= sat_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_offset_x  = out_offset_x_r;
  assign out_offset_y  = out_offset_y_r;
  assign out_saturated = out_saturated_r;

endmodule

// ===== rtl/core/fisheye_lens_distortion.sv =====
// Each point passes through 114 register stages on its way to a result:
// 33 for the square root, 32 for the arctangent, 33 for the divider, 16 for the polynomial.
// Throughput: one point per cycle; a stalled output holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and sets the four coefficients to 0.
module fisheye_lens_distortion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_offset_x,
  output logic signed [31:0] out_offset_y,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic                        en;
  logic signed [31:0]          coef_k1_r;
  logic signed [31:0]          coef_k2_r;
  logic signed [31:0]          coef_k3_r;
  logic signed [31:0]          coef_k4_r;
  logic                        sq_valid;
  logic [31:0]                 sq_root;
  fle_pkg::side_t              sq_side;
  logic                        co_valid;
  logic [fle_pkg::QW-1:0]      co_theta;
  logic [31:0]                 co_r;
  fle_pkg::side_t              co_side;
  logic                        dv_valid;
  logic [fle_pkg::QW-1:0]      dv_q;
  logic [fle_pkg::QW-1:0]      dv_theta;
  fle_pkg::side_t              dv_side;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_k1_r <= '0;
      coef_k2_r <= '0;
      coef_k3_r <= '0;
      coef_k4_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fle_pkg::CFG_K1: coef_k1_r <= cfg_data;
        fle_pkg::CFG_K2: coef_k2_r <= cfg_data;
        fle_pkg::CFG_K3: coef_k3_r <= cfg_data;
        fle_pkg::CFG_K4: coef_k4_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fle_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_u      (in_point_x),
    .in_v      (in_point_y),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  fle_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_r      (sq_root),
    .in_side   (sq_side),
    .out_valid (co_valid),
    .out_theta (co_theta),
    .out_r     (co_r),
    .out_side  (co_side)
  );

  fle_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (co_valid),
    .in_theta  (co_theta),
    .in_r      (co_r),
    .in_side   (co_side),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_theta (dv_theta),
    .out_side  (dv_side)
  );

  fle_poly u_poly (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (dv_valid),
    .in_theta      (dv_theta),
    .in_q          (dv_q),
    .in_side       (dv_side),
    .coef_k1       (coef_k1_r),
    .coef_k2       (coef_k2_r),
    .coef_k3       (coef_k3_r),
    .coef_k4       (coef_k4_r),
    .out_valid     (out_valid),
    .out_offset_x  (out_offset_x),
    .out_offset_y  (out_offset_y),
    .out_saturated (out_saturated)
  );

endmodule

// ===== rtl/core/fle_checker.sv =====
`include "assert_macros.svh"

module fle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_offset_x,
  input logic [31:0] out_offset_y,
  input logic        out_saturated,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result item stays on the port unchanged.
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_offset_x) && $stable(out_offset_y) && $stable(out_saturated))

  // A clipped item has at least one offset at the edge of the range.
  `CHK_NOW(a_sat_edge, out_valid && out_saturated, out_offset_x == 32'h7fff_ffff || out_offset_x == 32'h8000_0000 || out_offset_y == 32'h7fff_ffff || out_offset_y == 32'h8000_0000)

  // The input side only stalls when a result item is held back.
  `CHK_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // Register writes are always taken.
  `CHK_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind fisheye_lens_distortion fle_checker u_fle_checker (.*);
